@@ src/h264d_pkg.sv @@
// Shared types and constants of the H.264 RTP depacketizer.
package h264d_pkg;

  localparam int FILL_BITS = 21;
  localparam int CAP_BITS  = 21;
  localparam int CNT_BITS  = 21;
  localparam int SUM_BITS  = ((FILL_BITS > CNT_BITS) ? FILL_BITS : CNT_BITS) + 1;
  localparam int MAX_RUN   = 5;
  localparam int IDX_BITS  = 3;

  localparam logic [CAP_BITS-1:0] CAP_RESET = CAP_BITS'(65536);

  // parser phases
  localparam logic [3:0] PH_IDLE       = 4'd0;
  localparam logic [3:0] PH_DROP       = 4'd1;
  localparam logic [3:0] PH_SINGLE     = 4'd2;
  localparam logic [3:0] PH_SZ_HI      = 4'd3;
  localparam logic [3:0] PH_SZ_LO      = 4'd4;
  localparam logic [3:0] PH_UNIT_START = 4'd5;
  localparam logic [3:0] PH_UNIT_DATA  = 4'd6;
  localparam logic [3:0] PH_FU_HDR     = 4'd7;
  localparam logic [3:0] PH_FU_DATA    = 4'd8;

  // NAL unit types
  localparam logic [4:0] NAL_RSVD0  = 5'd0;
  localparam logic [4:0] NAL_STAP_B = 5'd25;
  localparam logic [4:0] NAL_MTAP16 = 5'd26;
  localparam logic [4:0] NAL_MTAP24 = 5'd27;
  localparam logic [4:0] NAL_STAP_A = 5'd24;
  localparam logic [4:0] NAL_FU_A   = 5'd28;
  localparam logic [4:0] NAL_FU_B   = 5'd29;
  localparam logic [4:0] NAL_RSVD30 = 5'd30;
  localparam logic [4:0] NAL_RSVD31 = 5'd31;

  localparam logic [7:0] TYPE_MASK  = 8'h1f;
  localparam logic [7:0] NRI_MASK   = 8'he0;
  localparam logic [7:0] FU_START   = 8'h80;

  localparam logic [3:0][7:0] START_CODE = {8'h01, 8'h00, 8'h00, 8'h00};

  // packet status codes
  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_UNSUPP    = 2'd1;
  localparam logic [1:0] ST_OVERFLOW  = 2'd2;
  localparam logic [1:0] ST_TRUNCATED = 2'd3;

  typedef struct packed {
    logic [7:0] data;
    logic       first;
    logic       last;
    logic       fbeg;
  } item_t;

  typedef struct packed {
    logic [IDX_BITS-1:0]      count;
    logic [MAX_RUN-1:0][7:0]  bytes;
    logic                     data_valid;
    logic                     done;
    logic [1:0]               status;
    logic [CNT_BITS-1:0]      added;
  } run_t;

endpackage

@@ src/h264d_parser.sv @@
// Packet parser: per-byte decode, capacity check and parser state.
module h264d_parser (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              cfg_we,
  input  logic [h264d_pkg::CAP_BITS-1:0]    cfg_data,
  input  h264d_pkg::item_t                  item,
  input  logic                              step,
  output h264d_pkg::run_t                   run
);

  logic [3:0]                         phase, phase_next;
  logic [7:0]                         indicator, indicator_next;
  logic [7:0]                         size_high, size_high_next;
  logic [15:0]                        remaining, remaining_next;
  logic [h264d_pkg::FILL_BITS-1:0]    fill, fill_next;
  logic [h264d_pkg::CNT_BITS-1:0]     added, added_next;
  logic [1:0]                         err, err_next;
  logic [h264d_pkg::CAP_BITS-1:0]     capacity;

  logic [h264d_pkg::FILL_BITS-1:0]    fill0;
  logic [h264d_pkg::CNT_BITS-1:0]     added0;
  logic [1:0]                         err0, err1;
  logic [3:0]                         phase1;
  logic                               ignore;
  logic [h264d_pkg::MAX_RUN-1:0][7:0] cand;
  logic [h264d_pkg::IDX_BITS-1:0]     cand_cnt, room, pushed;
  logic [h264d_pkg::SUM_BITS-1:0]     used, cap_ext, diff, commit_sum;
  logic [15:0]                        rem_dec;
  logic [4:0]                         kind;

  assign kind    = item.data[4:0] & h264d_pkg::TYPE_MASK[4:0];
  assign rem_dec = remaining - 16'd1;

  always_comb begin
    fill0          = (item.first && item.fbeg) ? '0 : fill;
    added0         = item.first ? '0 : added;
    err0           = item.first ? h264d_pkg::ST_OK : err;
    phase1         = phase;
    ignore         = 1'b0;
    cand           = '0;
    cand_cnt       = '0;
    indicator_next = indicator;
    size_high_next = size_high;
    remaining_next = remaining;
    if (item.first) begin
      indicator_next = item.data;
      unique case (kind) inside
        h264d_pkg::NAL_RSVD0, h264d_pkg::NAL_STAP_B, h264d_pkg::NAL_MTAP16,
        h264d_pkg::NAL_MTAP24, h264d_pkg::NAL_RSVD30, h264d_pkg::NAL_RSVD31: begin
          err0   = h264d_pkg::ST_UNSUPP;
          phase1 = h264d_pkg::PH_DROP;
        end
        h264d_pkg::NAL_STAP_A: phase1 = h264d_pkg::PH_SZ_HI;
        h264d_pkg::NAL_FU_A, h264d_pkg::NAL_FU_B: phase1 = h264d_pkg::PH_FU_HDR;
        default: begin
          cand     = {item.data, h264d_pkg::START_CODE};
          cand_cnt = 3'd5;
          phase1   = h264d_pkg::PH_SINGLE;
        end
      endcase
    end else begin
      unique case (phase) inside
        h264d_pkg::PH_DROP: ;
        h264d_pkg::PH_SINGLE, h264d_pkg::PH_FU_DATA: begin
          cand[0]  = item.data;
          cand_cnt = 3'd1;
        end
        h264d_pkg::PH_SZ_HI: begin
          size_high_next = item.data;
          phase1         = h264d_pkg::PH_SZ_LO;
        end
        h264d_pkg::PH_SZ_LO: begin
          remaining_next = {size_high, item.data};
          phase1         = h264d_pkg::PH_UNIT_START;
        end
        h264d_pkg::PH_UNIT_START: begin
          if (remaining == 16'd0) begin
            cand           = {8'h00, h264d_pkg::START_CODE};
            cand_cnt       = 3'd4;
            size_high_next = item.data;
            phase1         = h264d_pkg::PH_SZ_LO;
          end else begin
            cand           = {item.data, h264d_pkg::START_CODE};
            cand_cnt       = 3'd5;
            remaining_next = rem_dec;
            phase1 = (rem_dec != 16'd0) ? h264d_pkg::PH_UNIT_DATA : h264d_pkg::PH_SZ_HI;
          end
        end
        h264d_pkg::PH_UNIT_DATA: begin
          cand[0]        = item.data;
          cand_cnt       = 3'd1;
          remaining_next = rem_dec;
          if (rem_dec == 16'd0) phase1 = h264d_pkg::PH_SZ_HI;
        end
        h264d_pkg::PH_FU_HDR: begin
          if ((item.data & h264d_pkg::FU_START) != 8'h00) begin
            cand = {(indicator & h264d_pkg::NRI_MASK) | (item.data & h264d_pkg::TYPE_MASK),
                    h264d_pkg::START_CODE};
            cand_cnt = 3'd5;
          end
          phase1 = h264d_pkg::PH_FU_DATA;
        end
        default: ignore = 1'b1;
      endcase
    end
  end

  // room left in the frame store, clamped to one run
  always_comb begin
    used    = h264d_pkg::SUM_BITS'(fill0) + h264d_pkg::SUM_BITS'(added0);
    cap_ext = h264d_pkg::SUM_BITS'(capacity);
    diff    = cap_ext - used;
    if (cap_ext <= used) room = '0;
    else if (diff >= h264d_pkg::SUM_BITS'(h264d_pkg::MAX_RUN))
      room = h264d_pkg::IDX_BITS'(h264d_pkg::MAX_RUN);
    else room = diff[h264d_pkg::IDX_BITS-1:0];
  end

  always_comb begin
    pushed = '0;
    err1   = err0;
    if (err0 == h264d_pkg::ST_OK) begin
      if (cand_cnt > room) begin
        pushed = room;
        err1   = h264d_pkg::ST_OVERFLOW;
      end else begin
        pushed = cand_cnt;
      end
    end
    added_next = added0 + h264d_pkg::CNT_BITS'(pushed);
    err_next   = err1;
    phase_next = phase1;
    fill_next  = fill0;
    commit_sum = h264d_pkg::SUM_BITS'(fill0) + h264d_pkg::SUM_BITS'(added_next);

    run            = '0;
    run.bytes      = cand;
    run.count      = pushed;
    run.data_valid = 1'b1;
    if (item.last) begin
      if (phase1 == h264d_pkg::PH_FU_HDR && err1 == h264d_pkg::ST_OK)
        err_next = h264d_pkg::ST_TRUNCATED;
      phase_next = h264d_pkg::PH_IDLE;
      run.done   = 1'b1;
      run.status = err_next;
      if (pushed == '0) begin
        run.count      = 3'd1;
        run.data_valid = 1'b0;
      end
      if (err_next == h264d_pkg::ST_OK) begin
        run.added = added_next;
        fill_next = commit_sum[h264d_pkg::FILL_BITS-1:0];
      end
    end
    if (ignore) run = '0;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      capacity  <= h264d_pkg::CAP_RESET;
      phase     <= h264d_pkg::PH_IDLE;
      indicator <= '0;
      size_high <= '0;
      remaining <= '0;
      fill      <= '0;
      added     <= '0;
      err       <= h264d_pkg::ST_OK;
    end else begin
      if (cfg_we) capacity <= cfg_data;
      if (step && !ignore) begin
        phase     <= phase_next;
        indicator <= indicator_next;
        size_high <= size_high_next;
        remaining <= remaining_next;
        fill      <= fill_next;
        added     <= added_next;
        err       <= err_next;
      end
    end
  end

endmodule

@@ src/h264d_emitter.sv @@
// Result register: holds one run of up to five results and sends them out in order.
module h264d_emitter (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              load,
  input  h264d_pkg::run_t                   run_in,
  output logic                              free,
  output logic                              m_tvalid,
  input  logic                              m_tready,
  output logic [7:0]                        out_byte,
  output logic                              byte_valid,
  output logic                              run_last,
  output logic                              packet_done,
  output logic [1:0]                        packet_status,
  output logic [h264d_pkg::CNT_BITS-1:0]    packet_added
);

  logic                           busy;
  logic [h264d_pkg::IDX_BITS-1:0] idx;
  h264d_pkg::run_t                run;

  assign run_last      = (idx == run.count - 3'd1);
  assign free          = !busy || (m_tready && run_last);
  assign m_tvalid      = busy;
  assign out_byte      = run.data_valid ? run.bytes[idx] : 8'h00;
  assign byte_valid    = run.data_valid;
  assign packet_done   = run.done && run_last;
  assign packet_status = packet_done ? run.status : h264d_pkg::ST_OK;
  assign packet_added  = packet_done ? run.added : '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      idx  <= '0;
    end else if (load) begin
      busy <= 1'b1;
      idx  <= '0;
    end else if (busy && m_tready) begin
      if (run_last) busy <= 1'b0;
      else idx <= idx + 3'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (load) run <= run_in;
  end

endmodule

@@ src/h264_rtp_depacketizer_unit.sv @@
// Top level of the H.264 RTP depacketizer: input register, parser and result register.
//
//  channel  dir  handshake           payload
//  s_*      in   s_tvalid/s_tready   payload byte, packet and frame marks
//  m_*      out  m_tvalid/m_tready   Annex-B byte, status, byte count
//  cfg_*    in   cfg_we              frame capacity
//
// A payload byte that causes no result is taken at once; one that causes results
// waits for the single result register, which drains a run of up to four results
// for a start code, or five with the byte behind it, one transfer a cycle while
// m_tready is high. The input register takes the next byte while the last result
// of a run is being transferred. Reset is synchronous, clears parser state and sets
// capacity to 65536. Stalls on m_tready hold the run and, via the input register, s_tready.
module h264_rtp_depacketizer_unit (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              s_tvalid,
  output logic                              s_tready,
  input  logic [7:0]                        s_tdata,   // [7:0] payload_byte
  input  logic                              s_tlast,   // packet_last
  input  logic [1:0]                        s_tuser,   // [0] packet_first, [1] frame_begin
  output logic                              m_tvalid,
  input  logic                              m_tready,
  output logic [31:0]                       m_tdata,   // [7:0] out_byte, [28:8] packet_added
  output logic                              m_tlast,   // run_last
  output logic [3:0]                        m_tuser,   // [0] byte_valid, [1] packet_done,
                                                       // [3:2] packet_status
  input  logic                              cfg_we,
  input  logic [h264d_pkg::CAP_BITS-1:0]    cfg_data
);

  logic                           in_valid;
  h264d_pkg::item_t               item;
  h264d_pkg::run_t                run;
  logic                           free, take, load;
  logic [7:0]                     out_byte;
  logic                           byte_valid, packet_done;
  logic [1:0]                     packet_status;
  logic [h264d_pkg::CNT_BITS-1:0] packet_added;

  assign take     = in_valid && (free || run.count == '0);
  assign load     = take && run.count != '0;
  assign s_tready = !in_valid || take;

  always_ff @(posedge clk) begin
    if (rst) in_valid <= 1'b0;
    else if (s_tready) in_valid <= s_tvalid;
  end

  always_ff @(posedge clk) begin
    if (s_tready && s_tvalid) begin
      item.data  <= s_tdata;
      item.first <= s_tuser[0];
      item.last  <= s_tlast;
      item.fbeg  <= s_tuser[1];
    end
  end

  h264d_parser u_parser (
    .clk      (clk),
    .rst      (rst),
    .cfg_we   (cfg_we),
    .cfg_data (cfg_data),
    .item     (item),
    .step     (take),
    .run      (run)
  );

  h264d_emitter u_emitter (
    .clk           (clk),
    .rst           (rst),
    .load          (load),
    .run_in        (run),
    .free          (free),
    .m_tvalid      (m_tvalid),
    .m_tready      (m_tready),
    .out_byte      (out_byte),
    .byte_valid    (byte_valid),
    .run_last      (m_tlast),
    .packet_done   (packet_done),
    .packet_status (packet_status),
    .packet_added  (packet_added)
  );

  assign m_tdata = {3'b000, packet_added, out_byte};
  assign m_tuser = {packet_status, packet_done, byte_valid};

endmodule
